// ----- src/page_order_queue_top_macros.svh -----
// assertion macros for the page order queue checker
`ifndef PAGE_ORDER_QUEUE_TOP_MACROS_SVH
`define PAGE_ORDER_QUEUE_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define POQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define POQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define POQ_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/poq_pkg.sv -----
package poq_pkg;

    localparam int POQ_FRAMES    = 64;
    localparam int POQ_PAGE_BITS = 32;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_EVICT  = 2'd1,
        FN_TOUCH  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVRD,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [31:0] page;
    } t_poq_in;

    typedef struct packed {
        logic [31:0] evicted_page;
        t_status     status;
        logic [6:0]  occupancy;
    } t_poq_out;

endpackage

// ----- src/poq_ram.sv -----
module poq_ram
    import poq_pkg::*;
#(
    parameter int FRAMES    = POQ_FRAMES,
    parameter int PAGE_BITS = POQ_PAGE_BITS,
    localparam int AW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [PAGE_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [PAGE_BITS-1:0] o_rd_data
);

    logic [PAGE_BITS-1:0] r_mem [FRAMES];
    logic [PAGE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/page_order_queue_top.sv -----
// channel | direction | handshake                   | word
// input   | in        | i_in_valid / o_in_ready     | t_poq_in  (func, page)
// output  | out       | o_out_valid / i_out_ready   | t_poq_out (evicted_page, status, occupancy)
//
// append and no-op go from idle to done; evict takes its ram read through S_EVRD
// touch walks the stored pages through the single ram read port (S_SCAN, S_FINISH)
// pages live in a circular buffer; a touch closes the gap in the same pass as the search
// i_rst_n is synchronous and empties the store; no clearing pass is needed
// a new word is taken while the previous result still waits in the output register
module page_order_queue_top
    import poq_pkg::*;
#(
    parameter int FRAMES    = POQ_FRAMES,
    parameter int PAGE_BITS = POQ_PAGE_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_poq_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_poq_out o_out
);

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [PAGE_BITS-1:0] r_page;
    logic [CW-1:0]        r_rd_off;
    logic                 r_chk_vld;
    logic [AW-1:0]        r_chk_off;
    logic                 r_found;
    t_poq_out             r_res;
    logic                 r_out_valid;
    t_poq_out             r_out;

    logic                 w_accept;
    logic                 w_load_out;
    logic [PAGE_BITS-1:0] w_page_in;
    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [PAGE_BITS-1:0] w_wr_data;
    logic [PAGE_BITS-1:0] w_rdata;
    logic                 w_match;
    logic                 w_last;

    // offset from the oldest entry to a ram address
    function automatic logic [AW-1:0] off2addr(input logic [AW-1:0] head,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (AW+1)'(FRAMES)) begin
            sum = sum - (AW+1)'(FRAMES);
        end
        return sum[AW-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_page_in  = PAGE_BITS'(i_in.page);
    assign w_match    = r_chk_vld && !r_found && (w_rdata == r_page);
    assign w_last     = r_chk_vld && (CW'(r_chk_off) == r_count - 1'b1);

    poq_ram #(
        .FRAMES   (FRAMES),
        .PAGE_BITS(PAGE_BITS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.func)
                        FN_EVICT: n_state = (r_count == '0) ? S_DONE : S_EVRD;
                        FN_TOUCH: n_state = (r_count == '0) ? S_DONE : S_SCAN;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_EVRD:   n_state = S_DONE;
            S_SCAN:   n_state = w_last ? S_FINISH : S_SCAN;
            S_FINISH: n_state = S_DONE;
            S_DONE:   n_state = w_load_out ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = off2addr(r_head, r_rd_off[AW-1:0]);
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_page;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.func == FN_APPEND && r_count != CW'(FRAMES)) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = off2addr(r_head, r_count[AW-1:0]);
                        w_wr_data = w_page_in;
                    end
                    if (i_in.func == FN_EVICT && r_count != '0) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_head;
                    end
                end
            end
            S_SCAN: begin
                w_rd_en = (r_rd_off < r_count);
                // once the match is behind us, every later page slides down one
                if (r_chk_vld && r_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = off2addr(r_head, r_chk_off - 1'b1);
                    w_wr_data = w_rdata;
                end
            end
            S_FINISH: begin
                if (r_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = off2addr(r_head, AW'(r_count - 1'b1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_page             <= w_page_in;
                        r_rd_off           <= '0;
                        r_found            <= 1'b0;
                        r_chk_vld          <= 1'b0;
                        r_res.evicted_page <= '0;
                        case (i_in.func)
                            FN_APPEND: begin
                                if (r_count == CW'(FRAMES)) begin
                                    r_res.status    <= ST_FULL;
                                    r_res.occupancy <= 7'(r_count);
                                end else begin
                                    r_count         <= r_count + 1'b1;
                                    r_res.status    <= ST_OK;
                                    r_res.occupancy <= 7'(r_count) + 7'd1;
                                end
                            end
                            FN_EVICT, FN_TOUCH: begin
                                r_res.status    <= (r_count == '0) ? ST_EMPTY : ST_OK;
                                r_res.occupancy <= 7'(r_count);
                            end
                            default: begin
                                r_res.status    <= ST_OK;
                                r_res.occupancy <= 7'(r_count);
                            end
                        endcase
                    end
                end
                S_EVRD: begin
                    r_res.evicted_page <= 32'(w_rdata);
                    r_res.occupancy    <= 7'(r_count) - 7'd1;
                    r_count            <= r_count - 1'b1;
                    r_head             <= (r_head == AW'(FRAMES - 1)) ? '0 : r_head + 1'b1;
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_rd_off <= r_rd_off + 1'b1;
                    end
                    r_chk_vld <= w_rd_en;
                    r_chk_off <= r_rd_off[AW-1:0];
                    if (w_match) begin
                        r_found <= 1'b1;
                    end
                end
                S_FINISH: begin
                    r_res.status <= r_found ? ST_OK : ST_NOT_FOUND;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/poq_checker.sv -----
`include "page_order_queue_top_macros.svh"

module poq_checker
    import poq_pkg::*;
#(
    parameter int FRAMES = POQ_FRAMES
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_poq_out o_out
);

    `POQ_ASSERT_ALWAYS(a_rst_no_out, !i_rst_n, !o_out_valid, "result word shown right after reset")
    `POQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result word changed")
    `POQ_ASSERT_NOW(a_empty_zero, o_out_valid && o_out.status == ST_EMPTY, o_out.occupancy == 7'd0 && o_out.evicted_page == 32'd0, "empty status with pages held")
    `POQ_ASSERT_NOW(a_full_count, o_out_valid && o_out.status == ST_FULL, o_out.occupancy == 7'(FRAMES) && o_out.evicted_page == 32'd0, "full status below capacity")
    `POQ_ASSERT_NEXT(a_take_busy, i_in_valid && o_in_ready, !o_in_ready, "ready held after a word was taken")

endmodule

bind page_order_queue_top poq_checker #(.FRAMES(FRAMES)) u_poq_checker (.*);

// ----- bench/tb_page_order_queue_top.sv -----
`timescale 1ns / 1ps

module tb_page_order_queue_top;
    import poq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1200;
    localparam int TAIL_CYCLES    = 24;

    class page_order_scoreboard;
        logic [31:0] resident_pages[$];
        t_poq_out    pending_results[$];
        int          failures;
        int          results_checked;
        int          full_drops;
        int          empty_hits;
        int          touch_misses;
        int          touch_hits;
        int          peak_occupancy;

        function new();
            failures        = 0;
            results_checked = 0;
            full_drops      = 0;
            empty_hits      = 0;
            touch_misses    = 0;
            touch_hits      = 0;
            peak_occupancy  = 0;
        endfunction

        // age-ordered list: index 0 is the oldest page
        function t_poq_out age_list_step(t_poq_in w);
            t_poq_out r;
            int       hit_idx;
            r.evicted_page = '0;
            r.status       = ST_OK;
            hit_idx        = -1;
            case (w.func)
                FN_APPEND: begin
                    if (resident_pages.size() >= POQ_FRAMES) begin
                        r.status = ST_FULL;
                    end else begin
                        resident_pages.push_back(w.page);
                    end
                end
                FN_EVICT: begin
                    if (resident_pages.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.evicted_page = resident_pages.pop_front();
                    end
                end
                FN_TOUCH: begin
                    if (resident_pages.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // only the oldest copy moves
                        foreach (resident_pages[i]) begin
                            if (hit_idx < 0 && resident_pages[i] == w.page) begin
                                hit_idx = i;
                            end
                        end
                        if (hit_idx < 0) begin
                            r.status = ST_NOT_FOUND;
                        end else begin
                            resident_pages.delete(hit_idx);
                            resident_pages.push_back(w.page);
                        end
                    end
                end
                default: ;
            endcase
            r.occupancy = 7'(resident_pages.size());
            return r;
        endfunction

        function void note_request(t_poq_in w);
            t_poq_out r;
            r = age_list_step(w);
            pending_results.push_back(r);
            if (r.occupancy > peak_occupancy) begin
                peak_occupancy = r.occupancy;
            end
            case (r.status)
                ST_FULL:      full_drops++;
                ST_EMPTY:     empty_hits++;
                ST_NOT_FOUND: touch_misses++;
                default:      if (w.func == FN_TOUCH) touch_hits++;
            endcase
        endfunction

        function void check_result(t_poq_out got);
            t_poq_out want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: evicted_page %h status %0d occupancy %0d",
                       got.evicted_page, got.status, got.occupancy);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %h, actual %h", want.evicted_page,
                       got.evicted_page);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                failures++;
            end
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_poq_in  i_in;
    logic     o_out_valid;
    logic     i_out_ready;
    t_poq_out o_out;

    page_order_scoreboard sb;
    int                   snd_idle_pct;
    int                   rcv_idle_pct;
    int                   words_sent;
    int                   idle_cycles;
    logic [31:0]          page_pool[16];

    page_order_queue_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        snd_idle_pct = 32;
        rcv_idle_pct = 69;
        words_sent   = 0;
        idle_cycles  = 0;
        sb           = new();
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // result check first: a result can never belong to a word taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("page_order_queue_top test failed");
                $finish;
            end
        end
    end

    task automatic send_word(input t_func f, input logic [31:0] p);
        t_poq_in w;
        w.func = f;
        w.page = p;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // mostly pool pages so touches hit and duplicates build up
    function automatic logic [31:0] pick_page();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return page_pool[$urandom_range(0, 15)];
        end else if (sel == 7) begin
            return $urandom();
        end else if (sel == 8) begin
            return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        end
        // near miss: one bit off a pooled page
        return page_pool[$urandom_range(0, 15)] ^ (32'h1 << $urandom_range(0, 31));
    endfunction

    task automatic run_episode();
        int kind;
        int len;
        int sel;
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
            len = POQ_FRAMES + $urandom_range(0, 6);
            repeat (len) send_word(FN_APPEND, pick_page());
        end else if (kind == 1) begin
            len = POQ_FRAMES + $urandom_range(0, 6);
            repeat (len) send_word(FN_EVICT, $urandom());
        end else begin
            len = $urandom_range(20, 60);
            repeat (len) begin
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    send_word(FN_APPEND, pick_page());
                end else if (sel < 55) begin
                    send_word(FN_EVICT, $urandom());
                end else if (sel < 90) begin
                    send_word(FN_TOUCH, pick_page());
                end else begin
                    send_word(FN_NONE, $urandom());
                end
            end
        end
    endtask

    initial begin
        int directed_words;
        #1;
        page_pool[0] = 32'h0;
        page_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < 16; i++) begin
            page_pool[i] = $urandom();
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store corners
        send_word(FN_EVICT, 32'h0);
        send_word(FN_TOUCH, 32'h5);
        send_word(FN_NONE, 32'hffff_ffff);
        // duplicates, oldest copy moves on touch
        send_word(FN_APPEND, 32'h0);
        send_word(FN_APPEND, 32'hffff_ffff);
        send_word(FN_APPEND, 32'h0);
        send_word(FN_APPEND, 32'ha5a5_a5a5);
        send_word(FN_TOUCH, 32'h0);
        send_word(FN_TOUCH, 32'h1234_5678);
        send_word(FN_TOUCH, 32'hffff_ffff);
        send_word(FN_NONE, 32'h0);
        send_word(FN_TOUCH, 32'ha5a5_a5a4);
        repeat (5) send_word(FN_EVICT, 32'hffff_ffff);
        send_word(FN_TOUCH, 32'h0);
        send_word(FN_APPEND, 32'h5a5a_5a5a);
        send_word(FN_TOUCH, 32'h5a5a_5a5a);
        send_word(FN_EVICT, 32'h0);
        send_word(FN_APPEND, 32'h8000_0001);
        send_word(FN_EVICT, 32'h0);
        directed_words = words_sent;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 32;
                    rcv_idle_pct = 69;
                end
                1: begin
                    snd_idle_pct = 69;
                    rcv_idle_pct = 32;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            while (words_sent - directed_words < (ph + 1) * RANDOM_WORDS / 3) begin
                run_episode();
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending_count() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d results checked, peak occupancy %0d of %0d",
                 words_sent, sb.results_checked, sb.peak_occupancy, POQ_FRAMES);
        $display("appends dropped when full %0d, empty store %0d, touch hits %0d, misses %0d",
                 sb.full_drops, sb.empty_hits, sb.touch_hits, sb.touch_misses);
        if (sb.failures == 0) begin
            $display("page_order_queue_top test passed");
        end else begin
            $display("page_order_queue_top test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/poq_pkg.sv
src/poq_ram.sv
src/page_order_queue_top.sv
src/poq_checker.sv
bench/tb_page_order_queue_top.sv
